// File: sv/rft_pkg.sv
package rft_pkg;

  localparam int unsigned FRAME_BITS = 52;
  localparam int unsigned BIT_POS_W  = 6;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned ROLL_LEN   = 5;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SEND = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 4'd3;

  localparam logic [TICK_W-1:0] HEADER_RST = 16'd2400;
  localparam logic [TICK_W-1:0] SHORT_RST  = 16'd400;
  localparam logic [TICK_W-1:0] LONG_RST   = 16'd800;
  localparam logic [TICK_W-1:0] FOOTER_RST = 16'd24000;

  localparam logic [7:0] FRAME_FLAG = 8'hFE;
  localparam logic [7:0] TOKEN_RST  = 8'h7D;
  localparam logic [7:0] TOKEN_STEP = 8'd10;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_LOW    = 5'b00100,
    PH_HIGH   = 5'b01000,
    PH_FOOTER = 5'b10000
  } phase_e;

  typedef struct packed {
    logic        is_send;
    logic [3:0]  grp_chan;
    logic [15:0] address;
    logic        chan_keep;
    logic [3:0]  chan_code;
    logic [3:0]  state_nibble;
    logic [7:0]  repeat_count;
  } cmd_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [TICK_W-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic refused;
  } res_t;

  function automatic logic [3:0] chan_code(input logic [2:0] idx);
    logic [3:0] code;
    case (idx)
      3'd0: code = 4'd0;
      3'd1: code = 4'd8;
      3'd2: code = 4'd4;
      3'd3: code = 4'd2;
      3'd4: code = 4'd1;
      3'd5: code = 4'd3;
      3'd6: code = 4'd5;
      3'd7: code = 4'd6;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] roll_code(input logic [2:0] idx);
    logic [7:0] code;
    case (idx)
      3'd0: code = 8'h98;
      3'd1: code = 8'hDA;
      3'd2: code = 8'h1E;
      3'd3: code = 8'hE6;
      3'd4: code = 8'h67;
      default: code = 8'h98;
    endcase
    return code;
  endfunction

endpackage

// File: sv/rft_ifs.sv
interface rft_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  grp_chan;
  logic [15:0] address;
  logic [3:0]  channel;
  logic        light_on;
  logic [7:0]  repeat_count;

  modport source (output valid, func, grp_chan, address, channel, light_on,
                  repeat_count, input ready);
  modport sink (input valid, func, grp_chan, address, channel, light_on,
                repeat_count, output ready);
endinterface

interface rft_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic refused;

  modport source (output valid, line_level, busy_res, refused, input ready);
  modport sink (input valid, line_level, busy_res, refused, output ready);
endinterface

interface rft_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rft_pkg::CFG_IDX_W-1:0]    index;
  logic [rft_pkg::TICK_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/rf_remote_frame_transmitter.sv
// one word in and one word out per cycle when the output side keeps up
// a word is stored in the queue; its result is registered when the back pops it
// the front decodes into a short command queue, the back updates the frame state
// and the output register together when it pops a command
// asynchronous active-low reset: timing registers to defaults, line low, idle,
// token 0x7d, rolling index and frame cleared, queue and output emptied
module rf_remote_frame_transmitter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rft_in_if.sink     item_i,
  rft_out_if.source  result_o,
  rft_cfg_if.sink    cfg_i
);

  rft_pkg::cmd_t    cmd_in, cmd_out;
  rft_pkg::cfg_wr_t cfg_wr;
  rft_pkg::res_t    res;
  logic             push, full, q_valid, pop, res_valid;

  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  rft_front u_front (
    .in_valid_i       (item_i.valid),
    .in_ready_o       (item_i.ready),
    .func_i           (item_i.func),
    .grp_chan_i       (item_i.grp_chan),
    .address_i        (item_i.address),
    .channel_i        (item_i.channel),
    .light_on_i       (item_i.light_on),
    .repeat_count_i   (item_i.repeat_count),
    .push_o           (push),
    .full_i           (full),
    .cmd_o            (cmd_in)
  );

  rft_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (cmd_out)
  );

  rft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (pop),
    .cmd_i       (cmd_out),
    .res_valid_o (res_valid),
    .res_ready_i (result_o.ready),
    .res_o       (res)
  );

  assign result_o.valid      = res_valid;
  assign result_o.line_level = res.line_level;
  assign result_o.busy_res   = res.busy_res;
  assign result_o.refused    = res.refused;

endmodule

// File: sv/rft_front.sv
module rft_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [3:0]        grp_chan_i,
  input  logic [15:0]       address_i,
  input  logic [3:0]        channel_i,
  input  logic              light_on_i,
  input  logic [7:0]        repeat_count_i,
  output logic              push_o,
  input  logic              full_i,
  output rft_pkg::cmd_t     cmd_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.is_send        = (func_i == rft_pkg::FUNC_SEND);
    cmd_o.grp_chan       = grp_chan_i;
    cmd_o.address        = address_i;
    cmd_o.chan_keep      = channel_i[3];
    cmd_o.chan_code      = rft_pkg::chan_code(channel_i[2:0]);
    cmd_o.state_nibble   = {3'b000, !light_on_i};
    cmd_o.repeat_count   = repeat_count_i;
  end

endmodule

// File: sv/rft_queue.sv
module rft_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rft_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output rft_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rft_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: sv/rft_back.sv
module rft_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rft_pkg::cfg_wr_t cfg_i,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  input  rft_pkg::cmd_t    cmd_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output rft_pkg::res_t    res_o
);

  localparam logic [rft_pkg::BIT_POS_W-1:0] LastBit =
    rft_pkg::BIT_POS_W'(rft_pkg::FRAME_BITS - 1);
  localparam logic [rft_pkg::BIT_POS_W-1:0] NumBits =
    rft_pkg::BIT_POS_W'(rft_pkg::FRAME_BITS);
  localparam logic [2:0] RollLast = 3'(rft_pkg::ROLL_LEN - 1);

  logic [rft_pkg::TICK_W-1:0] header_q, short_q, long_q, footer_q;

  logic [rft_pkg::FRAME_BITS-1:0] frame_q, frame_d;
  logic [7:0]                     token_q, token_d;
  logic [2:0]                     roll_q, roll_d;
  rft_pkg::phase_e                phase_q, phase_d;
  logic [rft_pkg::BIT_POS_W-1:0]  bitpos_q, bitpos_d;
  logic [rft_pkg::TICK_W-1:0]     tick_q, tick_d;
  logic [7:0]                     reps_q, reps_d;
  logic                           line_q, line_d;

  logic                           out_valid_q;
  rft_pkg::res_t                  res_q, res_d;

  logic                           busy, cur_bit, done;
  logic [rft_pkg::TICK_W-1:0]     dur;
  logic [rft_pkg::TICK_W:0]       tick_inc;
  logic [2:0]                     roll_sel;
  logic [3:0]                     code;
  logic [7:0]                     reps_dec;

  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign busy    = (phase_q != rft_pkg::PH_IDLE);
  assign cur_bit = (bitpos_q < NumBits) ? frame_q[LastBit - bitpos_q] : 1'b0;
  assign tick_inc = {1'b0, tick_q} + 1'b1;
  assign done    = (tick_inc >= {1'b0, dur});
  assign roll_sel = (roll_q > RollLast) ? 3'd0 : roll_q;
  assign code    = cmd_i.chan_keep ? frame_q[23:20] : cmd_i.chan_code;
  assign reps_dec = (reps_q != '0) ? reps_q - 1'b1 : reps_q;

  always_comb begin
    case (phase_q)
      rft_pkg::PH_HEADER: dur = header_q;
      rft_pkg::PH_LOW:    dur = cur_bit ? short_q : long_q;
      rft_pkg::PH_HIGH:   dur = cur_bit ? long_q : short_q;
      rft_pkg::PH_FOOTER: dur = footer_q;
      default:            dur = header_q;
    endcase
  end

  always_comb begin
    frame_d  = frame_q;
    token_d  = token_q;
    roll_d   = roll_q;
    phase_d  = phase_q;
    bitpos_d = bitpos_q;
    tick_d   = tick_q;
    reps_d   = reps_q;
    line_d   = line_q;
    res_d.refused = 1'b0;

    if (cmd_i.is_send) begin
      if (busy) begin
        res_d.refused = 1'b1;
      end else begin
        frame_d = {rft_pkg::FRAME_FLAG, cmd_i.grp_chan, cmd_i.address, code,
                   cmd_i.state_nibble, rft_pkg::roll_code(roll_sel), token_q};
        token_d = token_q + rft_pkg::TOKEN_STEP;
        roll_d  = (roll_sel == RollLast) ? 3'd0 : roll_sel + 1'b1;
        if (cmd_i.repeat_count != '0) begin
          reps_d   = cmd_i.repeat_count;
          phase_d  = rft_pkg::PH_HEADER;
          bitpos_d = '0;
          tick_d   = '0;
          line_d   = 1'b1;
        end
      end
    end else if (busy) begin
      tick_d = done ? '0 : tick_inc[rft_pkg::TICK_W-1:0];
      if (done) begin
        case (phase_q)
          rft_pkg::PH_HEADER: begin
            phase_d  = rft_pkg::PH_LOW;
            bitpos_d = '0;
            line_d   = 1'b0;
          end
          rft_pkg::PH_LOW: begin
            phase_d = rft_pkg::PH_HIGH;
            line_d  = 1'b1;
          end
          rft_pkg::PH_HIGH: begin
            line_d = 1'b0;
            if (bitpos_q >= LastBit) begin
              phase_d = rft_pkg::PH_FOOTER;
            end else begin
              bitpos_d = bitpos_q + 1'b1;
              phase_d  = rft_pkg::PH_LOW;
            end
          end
          rft_pkg::PH_FOOTER: begin
            reps_d = reps_dec;
            if (reps_dec == '0) begin
              phase_d = rft_pkg::PH_IDLE;
              line_d  = 1'b0;
            end else begin
              phase_d  = rft_pkg::PH_HEADER;
              bitpos_d = '0;
              line_d   = 1'b1;
            end
          end
          default: phase_d = rft_pkg::PH_IDLE;
        endcase
      end
    end

    res_d.line_level = line_d;
    res_d.busy_res   = (phase_d != rft_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= rft_pkg::HEADER_RST;
      short_q     <= rft_pkg::SHORT_RST;
      long_q      <= rft_pkg::LONG_RST;
      footer_q    <= rft_pkg::FOOTER_RST;
      frame_q     <= '0;
      token_q     <= rft_pkg::TOKEN_RST;
      roll_q      <= '0;
      phase_q     <= rft_pkg::PH_IDLE;
      bitpos_q    <= '0;
      tick_q      <= '0;
      reps_q      <= '0;
      line_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          rft_pkg::REG_HEADER: header_q <= cfg_i.data;
          rft_pkg::REG_SHORT:  short_q  <= cfg_i.data;
          rft_pkg::REG_LONG:   long_q   <= cfg_i.data;
          rft_pkg::REG_FOOTER: footer_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (cmd_pop_o) begin
        frame_q  <= frame_d;
        token_q  <= token_d;
        roll_q   <= roll_d;
        phase_q  <= phase_d;
        bitpos_q <= bitpos_d;
        tick_q   <= tick_d;
        reps_q   <= reps_d;
        line_q   <= line_d;
      end
      if (cmd_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule
